### src/mfc_pkg.sv
// ----------------------------------------------------------------------------
// mfc_pkg
// Shared widths, codes and types of the clipped-window median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package mfc_pkg;

    localparam int PIX_W        = 8;
    localparam int ROW_W        = 12;
    localparam int POS_W        = 13;
    localparam int DIM_W        = 13;
    localparam int OFF_W        = 3;
    localparam int RING_W       = 5;
    localparam int OUT_COL_W    = 10;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int WS_W         = 3;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int HEIGHT_LIMIT = 4096;

    localparam logic KIND_PIXEL = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_WINDOW = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GATHER,
        ST_DRAIN,
        ST_SHIFT,
        ST_PUT
    } back_state_t;

    // effective frame geometry after clamping
    typedef struct packed {
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [OFF_W-1:0] off;
    } geom_t;

    // one output pixel to compute
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [RING_W-1:0] ring;
        logic              last;
        logic              err;
    } job_t;

    // row store write request
    typedef struct packed {
        logic              en;
        logic [RING_W-1:0] ring;
        logic [POS_W-1:0]  col;
        logic [PIX_W-1:0]  data;
    } wr_t;

endpackage

`default_nettype wire

### src/mfc_queue.sv
// ----------------------------------------------------------------------------
// mfc_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mfc_queue (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  mfc_pkg::job_t     push_job,
    input  wire logic         pop,
    output mfc_pkg::job_t     head,
    output logic              not_empty,
    output logic              full
);
    import mfc_pkg::*;

    job_t       slot_reg [2];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       rd_reg;
    logic       rd_next;
    logic       wr_reg;
    logic       wr_next;

    assign head      = slot_reg[rd_reg];
    assign not_empty = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);

    always_comb
    begin
        count_next = count_reg;
        rd_next    = rd_reg;
        wr_next    = wr_reg;
        if (push)
        begin
            wr_next = ~wr_reg;
        end
        if (pop)
        begin
            rd_next = ~rd_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            rd_reg    <= 1'b0;
            wr_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            rd_reg    <= rd_next;
            wr_reg    <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

### src/mfc_front.sv
// ----------------------------------------------------------------------------
// mfc_front
// Configuration registers, input counters, row store writes and the
// decision which output pixel has its window complete.
// ----------------------------------------------------------------------------
`default_nettype none

module mfc_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_WINDOW = 7,
    parameter int STORE_ROWS = 14
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [mfc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mfc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            kind,
    input  wire logic [mfc_pkg::PIX_W-1:0]       pixel,
    input  wire logic                            back_empty,
    input  wire logic                            q_full,
    output logic                                 push,
    output mfc_pkg::job_t                        job,
    output mfc_pkg::wr_t                         wr,
    output mfc_pkg::geom_t                       geom
);
    import mfc_pkg::*;

    localparam int LIM_A = (MAX_WINDOW - 1) / 2;
    localparam int LIM_B = (STORE_ROWS - 2) / 2;
    localparam int LIM   = (LIM_A < LIM_B) ? LIM_A : LIM_B;

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [WS_W-1:0]         ws_reg;

    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [POS_W-1:0]  in_col_reg, in_col_next;
    logic [RING_W-1:0] in_ring_reg, in_ring_next;
    logic              done_reg, done_next;
    logic [ROW_W-1:0]  emit_row_reg, emit_row_next;
    logic [POS_W-1:0]  emit_col_reg, emit_col_next;
    logic [RING_W-1:0] emit_ring_reg, emit_ring_next;

    logic              accept;
    logic              take_pix;
    logic              at_start;
    logic              win_ready;
    logic              last;
    logic [DIM_W-1:0]  need_row;
    logic [POS_W-1:0]  need_col;
    logic [DIM_W-1:0]  row_hi;
    logic [POS_W-1:0]  col_hi;
    logic [OFF_W-1:0]  off_raw;
    logic [RING_W-1:0] r0_ring;

    // clamp the register values
    always_comb
    begin
        if (width_reg == '0)
        begin
            geom.w = DIM_W'(1);
        end
        else if (DIM_W'(width_reg) > DIM_W'(MAX_WIDTH))
        begin
            geom.w = DIM_W'(MAX_WIDTH);
        end
        else
        begin
            geom.w = DIM_W'(width_reg);
        end
        if (height_reg == '0)
        begin
            geom.h = DIM_W'(1);
        end
        else if (DIM_W'(height_reg) > DIM_W'(HEIGHT_LIMIT))
        begin
            geom.h = DIM_W'(HEIGHT_LIMIT);
        end
        else
        begin
            geom.h = DIM_W'(height_reg);
        end
        off_raw  = OFF_W'(ws_reg >> 1);
        geom.off = (off_raw > OFF_W'(LIM)) ? OFF_W'(LIM) : off_raw;
    end

    // hold the first pixel of a frame until the back has finished the last one
    assign at_start = (in_row_reg == '0) && (in_col_reg == '0) && !done_reg
                   && (emit_row_reg == '0) && (emit_col_reg == '0);
    assign in_ready = !q_full && !(at_start && !back_empty);
    assign accept   = in_valid && in_ready;
    assign take_pix = (kind == KIND_PIXEL) && !done_reg;

    assign wr.en   = accept && take_pix;
    assign wr.ring = in_ring_reg;
    assign wr.col  = in_col_reg;
    assign wr.data = pixel;

    // input position after this request
    always_comb
    begin
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        in_ring_next = in_ring_reg;
        done_next    = done_reg;
        if (take_pix)
        begin
            if (in_col_reg + POS_W'(1) >= POS_W'(geom.w))
            begin
                in_col_next = '0;
                if (DIM_W'(in_row_reg) + DIM_W'(1) >= geom.h)
                begin
                    in_row_next  = '0;
                    in_ring_next = '0;
                    done_next    = 1'b1;
                end
                else
                begin
                    in_row_next  = in_row_reg + ROW_W'(1);
                    in_ring_next = (in_ring_reg == RING_W'(STORE_ROWS - 1)) ? '0
                                 : in_ring_reg + RING_W'(1);
                end
            end
            else
            begin
                in_col_next = in_col_reg + POS_W'(1);
            end
        end
    end

    always_comb
    begin
        row_hi    = DIM_W'(emit_row_reg) + DIM_W'(geom.off);
        col_hi    = emit_col_reg + POS_W'(geom.off);
        need_row  = (row_hi < geom.h) ? row_hi : geom.h - DIM_W'(1);
        need_col  = (col_hi < POS_W'(geom.w)) ? col_hi : POS_W'(geom.w) - POS_W'(1);
        win_ready = done_next || (DIM_W'(in_row_next) > need_row)
                 || ((DIM_W'(in_row_next) == need_row) && (in_col_next > need_col));
        last      = (DIM_W'(emit_row_reg) == geom.h - DIM_W'(1))
                 && (emit_col_reg == POS_W'(geom.w) - POS_W'(1));
        if (DIM_W'(emit_row_reg) < DIM_W'(geom.off))
        begin
            r0_ring = '0;
        end
        else if (emit_ring_reg >= RING_W'(geom.off))
        begin
            r0_ring = emit_ring_reg - RING_W'(geom.off);
        end
        else
        begin
            r0_ring = emit_ring_reg + RING_W'(STORE_ROWS) - RING_W'(geom.off);
        end
    end

    assign push     = accept && win_ready;
    assign job.row  = emit_row_reg;
    assign job.col  = emit_col_reg;
    assign job.ring = r0_ring;
    assign job.last = last;
    assign job.err  = !ws_reg[0];

    // advance the emit position
    always_comb
    begin
        emit_row_next  = emit_row_reg;
        emit_col_next  = emit_col_reg;
        emit_ring_next = emit_ring_reg;
        if (emit_col_reg + POS_W'(1) >= POS_W'(geom.w))
        begin
            emit_col_next  = '0;
            emit_row_next  = emit_row_reg + ROW_W'(1);
            emit_ring_next = (emit_ring_reg == RING_W'(STORE_ROWS - 1)) ? '0
                           : emit_ring_reg + RING_W'(1);
        end
        else
        begin
            emit_col_next = emit_col_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_REG_W'(1);
            height_reg    <= HEIGHT_REG_W'(1);
            ws_reg        <= WS_W'(3);
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            in_ring_reg   <= '0;
            done_reg      <= 1'b0;
            emit_row_reg  <= '0;
            emit_col_reg  <= '0;
            emit_ring_reg <= '0;
        end
        else if (cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT
                            || cfg_index == REG_WINDOW))
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[WIDTH_REG_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[HEIGHT_REG_W-1:0];
                default:    ws_reg     <= cfg_data[WS_W-1:0];
            endcase
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            in_ring_reg   <= '0;
            done_reg      <= 1'b0;
            emit_row_reg  <= '0;
            emit_col_reg  <= '0;
            emit_ring_reg <= '0;
        end
        else if (accept)
        begin
            if (push && last)
            begin
                // frame complete: restart
                in_row_reg    <= '0;
                in_col_reg    <= '0;
                in_ring_reg   <= '0;
                done_reg      <= 1'b0;
                emit_row_reg  <= '0;
                emit_col_reg  <= '0;
                emit_ring_reg <= '0;
            end
            else
            begin
                in_row_reg  <= in_row_next;
                in_col_reg  <= in_col_next;
                in_ring_reg <= in_ring_next;
                done_reg    <= done_next;
                if (push)
                begin
                    emit_row_reg  <= emit_row_next;
                    emit_col_reg  <= emit_col_next;
                    emit_ring_reg <= emit_ring_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

### src/mfc_back.sv
// ----------------------------------------------------------------------------
// mfc_back
// Row store, window gather, insertion sort and median pick for one job.
// ----------------------------------------------------------------------------
`default_nettype none

module mfc_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_WINDOW = 7,
    parameter int STORE_ROWS = 14
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  mfc_pkg::wr_t                          wr,
    input  mfc_pkg::geom_t                        geom,
    input  wire logic                             q_valid,
    input  mfc_pkg::job_t                         q_job,
    output logic                                  pop,
    output logic                                  idle,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [mfc_pkg::PIX_W-1:0]             filtered,
    output logic [mfc_pkg::ROW_W-1:0]             out_row,
    output logic [mfc_pkg::OUT_COL_W-1:0]         out_col,
    output logic                                  frame_end,
    output logic                                  size_error
);
    import mfc_pkg::*;

    localparam int DEPTH  = STORE_ROWS * MAX_WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int SORT_N = MAX_WINDOW * MAX_WINDOW;
    localparam int NW     = $clog2(SORT_N + 1);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rd_q;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;

    back_state_t state_reg, state_next;

    logic [ROW_W-1:0]  r_reg, r_next;
    logic [ROW_W-1:0]  r1_reg, r1_next;
    logic [POS_W-1:0]  c_reg, c_next;
    logic [POS_W-1:0]  c0_reg, c0_next;
    logic [POS_W-1:0]  c1_reg, c1_next;
    logic [RING_W-1:0] ring_reg, ring_next;
    job_t              job_reg, job_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [NW-1:0]     n_reg, n_next;
    logic [NW-1:0]     shift_reg, shift_next;
    logic [PIX_W-1:0]  sb_reg [SORT_N];
    logic [PIX_W-1:0]  sb_next [SORT_N];
    logic [SORT_N-1:0] gt;

    logic              out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]  value_reg, value_next;
    job_t              res_reg, res_next;

    logic              issue_last;
    logic              slot_free;
    logic [ROW_W:0]    row_hi;
    logic [POS_W-1:0]  col_hi;
    logic [PIX_W:0]    mid_sum;

    assign wr_addr = AW'(wr.ring) * AW'(MAX_WIDTH) + AW'(wr.col);
    assign rd_addr = AW'(ring_reg) * AW'(MAX_WIDTH) + AW'(c_reg);

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr.data;
        end
        rd_q <= mem[rd_addr];
    end

    assign issue_last = (r_reg == r1_reg) && (c_reg == c1_reg);
    assign slot_free  = !out_valid_reg || out_ready;
    assign idle       = (state_reg == ST_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = q_job.err ? ST_PUT : ST_GATHER;
                end
            end
            ST_GATHER:
            begin
                if (issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (shift_reg == '0)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // insertion of the word read last cycle; compares are independent
    always_comb
    begin
        for (int i = 0; i < SORT_N; i++)
        begin
            gt[i] = (NW'(i) < n_reg) && (sb_reg[i] > rd_q);
        end
    end

    // datapath
    always_comb
    begin
        pop            = 1'b0;
        r_next         = r_reg;
        r1_next        = r1_reg;
        c_next         = c_reg;
        c0_next        = c0_reg;
        c1_next        = c1_reg;
        ring_next      = ring_reg;
        job_next       = job_reg;
        n_next         = n_reg;
        shift_next     = shift_reg;
        rd_valid_next  = (state_reg == ST_GATHER);
        out_valid_next = out_valid_reg && !out_ready;
        value_next     = value_reg;
        res_next       = res_reg;
        row_hi         = '0;
        col_hi         = '0;
        mid_sum        = '0;
        for (int i = 0; i < SORT_N; i++)
        begin
            sb_next[i] = sb_reg[i];
        end

        if (rd_valid_reg)
        begin
            for (int i = 0; i < SORT_N; i++)
            begin
                if ((NW'(i) < n_reg) && !gt[i])
                begin
                    sb_next[i] = sb_reg[i];
                end
                else if ((i > 0) && gt[(i > 0) ? i - 1 : 0])
                begin
                    sb_next[i] = sb_reg[(i > 0) ? i - 1 : 0];
                end
                else if (NW'(i) <= n_reg)
                begin
                    sb_next[i] = rd_q;
                end
            end
            n_next = n_reg + NW'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop      = 1'b1;
                    job_next = q_job;
                    n_next   = '0;
                    // clip the window to the frame
                    r_next = (q_job.row >= ROW_W'(geom.off)) ? q_job.row - ROW_W'(geom.off)
                           : '0;
                    row_hi = {1'b0, q_job.row} + (ROW_W + 1)'(geom.off);
                    r1_next = (DIM_W'(row_hi) < geom.h) ? row_hi[ROW_W-1:0]
                            : ROW_W'(geom.h - DIM_W'(1));
                    c0_next = (q_job.col >= POS_W'(geom.off)) ? q_job.col - POS_W'(geom.off)
                            : '0;
                    c_next  = c0_next;
                    col_hi  = q_job.col + POS_W'(geom.off);
                    c1_next = (col_hi < POS_W'(geom.w)) ? col_hi
                            : POS_W'(geom.w) - POS_W'(1);
                    ring_next = q_job.ring;
                end
            end
            ST_GATHER:
            begin
                if (c_reg == c1_reg)
                begin
                    c_next    = c0_reg;
                    r_next    = r_reg + ROW_W'(1);
                    ring_next = (ring_reg == RING_W'(STORE_ROWS - 1)) ? '0
                              : ring_reg + RING_W'(1);
                end
                else
                begin
                    c_next = c_reg + POS_W'(1);
                end
            end
            ST_DRAIN:
            begin
                // the last word lands now: count after insert is n_reg + 1
                shift_next = n_reg >> 1;
            end
            ST_SHIFT:
            begin
                if (shift_reg != '0)
                begin
                    for (int i = 0; i < SORT_N - 1; i++)
                    begin
                        sb_next[i] = sb_reg[i + 1];
                    end
                    shift_next = shift_reg - NW'(1);
                end
            end
            ST_PUT:
            begin
                if (slot_free)
                begin
                    mid_sum        = {1'b0, sb_reg[0]} + {1'b0, sb_reg[1]} + (PIX_W + 1)'(1);
                    out_valid_next = 1'b1;
                    res_next       = job_reg;
                    if (job_reg.err)
                    begin
                        value_next = '0;
                    end
                    else if (n_reg[0])
                    begin
                        value_next = sb_reg[0];
                    end
                    else
                    begin
                        value_next = mid_sum[PIX_W:1];
                    end
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg     <= r_next;
        r1_reg    <= r1_next;
        c_reg     <= c_next;
        c0_reg    <= c0_next;
        c1_reg    <= c1_next;
        ring_reg  <= ring_next;
        job_reg   <= job_next;
        n_reg     <= n_next;
        shift_reg <= shift_next;
        value_reg <= value_next;
        res_reg   <= res_next;
        for (int i = 0; i < SORT_N; i++)
        begin
            sb_reg[i] <= sb_next[i];
        end
    end

    assign out_valid  = out_valid_reg;
    assign filtered   = value_reg;
    assign out_row    = res_reg.row;
    assign out_col    = OUT_COL_W'(res_reg.col);
    assign frame_end  = res_reg.last;
    assign size_error = res_reg.err;

endmodule

`default_nettype wire

### src/median_filter_clipped_window.sv
// ----------------------------------------------------------------------------
// median_filter_clipped_window
// Streaming 2-D median filter over grey pixels with a border-clipped window.
// ----------------------------------------------------------------------------
//  channel | signals                              | transfer
//  --------+--------------------------------------+---------------------------
//  in      | in_valid/in_ready, kind, pixel        | valid & ready
//  out     | out_valid/out_ready, filtered, out_row,| valid & ready
//          | out_col, frame_end, size_error        |
//  cfg     | cfg_we, cfg_index, cfg_data           | write on cfg_we
//
// For a window of n pixels the back does one row store read per window
// pixel and one insertion per read, then a shift to the middle. Up to two
// jobs queue between front and back, so requests keep flowing while the
// back sorts; the first pixel of a frame waits for the back to go empty.
// Reset clears control state only; the row store has no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module median_filter_clipped_window #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_WINDOW = 7,
    parameter int STORE_ROWS = 14
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [mfc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mfc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             kind,
    input  wire logic [mfc_pkg::PIX_W-1:0]        pixel,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [mfc_pkg::PIX_W-1:0]             filtered,
    output logic [mfc_pkg::ROW_W-1:0]             out_row,
    output logic [mfc_pkg::OUT_COL_W-1:0]         out_col,
    output logic                                  frame_end,
    output logic                                  size_error
);
    import mfc_pkg::*;

    job_t  push_job;
    job_t  head;
    wr_t   wr;
    geom_t geom;
    logic  push;
    logic  pop;
    logic  not_empty;
    logic  full;
    logic  back_idle;

    mfc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_WINDOW (MAX_WINDOW),
        .STORE_ROWS (STORE_ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .pixel      (pixel),
        .back_empty (back_idle && !not_empty),
        .q_full     (full),
        .push       (push),
        .job        (push_job),
        .wr         (wr),
        .geom       (geom)
    );

    mfc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .full      (full)
    );

    mfc_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_WINDOW (MAX_WINDOW),
        .STORE_ROWS (STORE_ROWS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .geom       (geom),
        .q_valid    (not_empty),
        .q_job      (head),
        .pop        (pop),
        .idle       (back_idle),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .filtered   (filtered),
        .out_row    (out_row),
        .out_col    (out_col),
        .frame_end  (frame_end),
        .size_error (size_error)
    );

endmodule

`default_nettype wire
